// ===== src/huffman_tree_builder_core_macros.svh =====
// ----------------------------------------------------------------------------
// Huffman tree builder assertion macros
// Shared assertion forms for the checker of the Huffman tree builder.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_TREE_BUILDER_CORE_MACROS_SVH
`define HUFFMAN_TREE_BUILDER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HUFB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hufb checker: property violated");

// The consequent must hold in the cycle after the antecedent.
`define HUFB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hufb checker: property violated");

`endif

// ===== src/hufb_pkg.sv =====
// ----------------------------------------------------------------------------
// Huffman tree builder package
// Types, codes and widths shared by the controller, datapath and checker.
// ----------------------------------------------------------------------------
package hufb_pkg;

    localparam int MODE_W = 2;
    localparam int SYM_W  = 8;
    localparam int LEAF_W = 24;
    localparam int NODE_W = 9;
    localparam int CNT_W  = 32;
    localparam int STAT_W = 2;
    localparam int IDX_W  = 9;
    localparam int MRG_W  = 8;

    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MERGE = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] ST_LOW_ROOTS = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SYM_W-1:0]  symbol;
        logic [LEAF_W-1:0] leaf_count;
    } item_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [NODE_W-1:0] left_node;
        logic [NODE_W-1:0] right_node;
        logic [SYM_W-1:0]  left_symbol;
        logic [SYM_W-1:0]  right_symbol;
        logic [NODE_W-1:0] new_node;
        logic [CNT_W-1:0]  merged_count;
        logic [IDX_W-1:0]  roots_left;
    } result_t;

    typedef struct packed {
        logic [NODE_W-1:0] id;
        logic [CNT_W-1:0]  cnt;
    } root_t;

    typedef struct packed {
        logic capture;
        logic decode;
        logic scan;
        logic merge;
        logic sym_l;
        logic sym_r;
        logic shift;
        logic publish;
    } ctl_cmd_t;

    typedef struct packed {
        logic merge_go;
        logic scan_done;
        logic shift_done;
        logic out_free;
    } ctl_sts_t;

endpackage

// ===== src/hufb_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hufb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/hufb_ctrl.sv =====
// ----------------------------------------------------------------------------
// Huffman tree builder controller
// Sequences decode, minimum scan, merge, symbol lookup, list shift and result.
// ----------------------------------------------------------------------------
module hufb_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  hufb_pkg::ctl_sts_t sts,
    output hufb_pkg::ctl_cmd_t cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_MERGE  = 3'd3;
    localparam logic [2:0] S_SYML   = 3'd4;
    localparam logic [2:0] S_SYMR   = 3'd5;
    localparam logic [2:0] S_SHIFT  = 3'd6;
    localparam logic [2:0] S_FINISH = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.capture = item_valid;
                if (item_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                state_next = sts.merge_go ? S_SCAN : S_FINISH;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_MERGE;
                end
            end
            S_MERGE:
            begin
                cmd.merge  = 1'b1;
                state_next = S_SYML;
            end
            S_SYML:
            begin
                cmd.sym_l  = 1'b1;
                state_next = S_SYMR;
            end
            S_SYMR:
            begin
                cmd.sym_r  = 1'b1;
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (sts.shift_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                cmd.publish = sts.out_free;
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign item_stall = (state_reg != S_IDLE);

endmodule

// ===== src/hufb_datapath.sv =====
// ----------------------------------------------------------------------------
// Huffman tree builder datapath
// Root list and leaf symbol memories, minimum search, merge and result register.
// ----------------------------------------------------------------------------
module hufb_datapath #(
    parameter int CAPACITY = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  hufb_pkg::item_t    item,
    input  hufb_pkg::ctl_cmd_t cmd,
    output hufb_pkg::ctl_sts_t sts,
    output logic               result_valid,
    input  logic               result_stall,
    output hufb_pkg::result_t  result
);

    localparam int AW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int ROOT_W = hufb_pkg::NODE_W + hufb_pkg::CNT_W;
    localparam logic [hufb_pkg::NODE_W-1:0] CAP_ID = hufb_pkg::NODE_W'(CAPACITY);

    hufb_pkg::item_t   item_reg;
    hufb_pkg::result_t res_reg;
    hufb_pkg::result_t res_next;
    hufb_pkg::result_t out_reg;
    logic              out_vld_reg;

    logic [hufb_pkg::IDX_W-1:0] total_reg;
    logic [hufb_pkg::IDX_W-1:0] total_next;
    logic [hufb_pkg::IDX_W-1:0] leaves_reg;
    logic [hufb_pkg::IDX_W-1:0] leaves_next;
    logic [hufb_pkg::MRG_W-1:0] merges_reg;
    logic [hufb_pkg::MRG_W-1:0] merges_next;
    logic [hufb_pkg::IDX_W-1:0] rd_idx_reg;
    logic [hufb_pkg::IDX_W-1:0] rd_idx_next;
    logic [hufb_pkg::IDX_W-1:0] rd_pend_reg;
    logic                       rd_vld_reg;

    logic [hufb_pkg::CNT_W-1:0]  m1_cnt_reg;
    logic [hufb_pkg::IDX_W-1:0]  m1_idx_reg;
    logic [hufb_pkg::NODE_W-1:0] m1_id_reg;
    logic [hufb_pkg::CNT_W-1:0]  m2_cnt_reg;
    logic [hufb_pkg::IDX_W-1:0]  m2_idx_reg;
    logic [hufb_pkg::NODE_W-1:0] m2_id_reg;
    logic                        m2_ok_reg;

    logic                        issue;
    logic                        shift_more;
    logic                        load_ok;
    logic                        lo_is_m1;
    logic [hufb_pkg::IDX_W-1:0]  lo_idx;
    logic [hufb_pkg::IDX_W-1:0]  hi_idx;
    logic [hufb_pkg::NODE_W-1:0] lo_id;
    logic [hufb_pkg::NODE_W-1:0] hi_id;
    logic [hufb_pkg::CNT_W-1:0]  sum;
    logic [hufb_pkg::NODE_W-1:0] nid;
    logic [hufb_pkg::IDX_W-1:0]  shift_dst;
    logic [hufb_pkg::CNT_W-1:0]  leaf_cnt;

    logic                        root_we;
    logic [AW-1:0]               root_waddr;
    hufb_pkg::root_t             root_wdata;
    hufb_pkg::root_t             root_rdata;
    logic                        sym_we;
    logic                        sym_re;
    logic [AW-1:0]               sym_raddr;
    logic [hufb_pkg::SYM_W-1:0]  sym_rdata;

    assign leaf_cnt   = {{(hufb_pkg::CNT_W - hufb_pkg::LEAF_W){1'b0}}, item_reg.leaf_count};
    assign load_ok    = (leaves_reg < CAP_ID) && (total_reg < CAP_ID);
    assign shift_more = (rd_idx_reg <= total_reg);
    assign issue      = (cmd.scan && (rd_idx_reg < total_reg)) || (cmd.shift && shift_more);
    assign lo_is_m1   = (m1_idx_reg < m2_idx_reg);
    assign lo_idx     = lo_is_m1 ? m1_idx_reg : m2_idx_reg;
    assign hi_idx     = lo_is_m1 ? m2_idx_reg : m1_idx_reg;
    assign lo_id      = lo_is_m1 ? m1_id_reg : m2_id_reg;
    assign hi_id      = lo_is_m1 ? m2_id_reg : m1_id_reg;
    assign sum        = m1_cnt_reg + m2_cnt_reg;
    assign nid        = CAP_ID + {1'b0, merges_reg};
    assign shift_dst  = rd_pend_reg - 9'd1;

    assign sts.merge_go   = (item_reg.mode == hufb_pkg::MODE_MERGE) && (total_reg >= 9'd2);
    assign sts.scan_done  = rd_vld_reg && (rd_pend_reg == (total_reg - 9'd1));
    assign sts.shift_done = !shift_more && !rd_vld_reg;
    assign sts.out_free   = !out_vld_reg || !result_stall;

    always_comb
    begin
        root_we    = 1'b0;
        root_waddr = shift_dst[AW-1:0];
        root_wdata = root_rdata;
        if (cmd.decode && (item_reg.mode == hufb_pkg::MODE_LOAD) && load_ok)
        begin
            root_we    = 1'b1;
            root_waddr = total_reg[AW-1:0];
            root_wdata = '{id: leaves_reg, cnt: leaf_cnt};
        end
        else if (cmd.merge)
        begin
            root_we    = 1'b1;
            root_waddr = lo_idx[AW-1:0];
            root_wdata = '{id: nid, cnt: sum};
        end
        else if (cmd.shift && rd_vld_reg)
        begin
            root_we = 1'b1;
        end
    end

    assign sym_we    = cmd.decode && (item_reg.mode == hufb_pkg::MODE_LOAD) && load_ok;
    assign sym_re    = cmd.merge || cmd.sym_l;
    assign sym_raddr = cmd.merge ? lo_id[AW-1:0] : hi_id[AW-1:0];

    hufb_ram #(
        .WIDTH (ROOT_W),
        .DEPTH (CAPACITY)
    ) u_root_ram (
        .clk   (clk),
        .we    (root_we),
        .waddr (root_waddr),
        .wdata (root_wdata),
        .re    (issue),
        .raddr (rd_idx_reg[AW-1:0]),
        .rdata (root_rdata)
    );

    hufb_ram #(
        .WIDTH (hufb_pkg::SYM_W),
        .DEPTH (CAPACITY)
    ) u_sym_ram (
        .clk   (clk),
        .we    (sym_we),
        .waddr (leaves_reg[AW-1:0]),
        .wdata (item_reg.symbol),
        .re    (sym_re),
        .raddr (sym_raddr),
        .rdata (sym_rdata)
    );

    always_comb
    begin
        total_next  = total_reg;
        leaves_next = leaves_reg;
        merges_next = merges_reg;
        rd_idx_next = rd_idx_reg;
        res_next    = res_reg;
        if (cmd.decode)
        begin
            rd_idx_next         = '0;
            res_next            = '0;
            res_next.roots_left = total_reg;
            unique case (item_reg.mode)
                hufb_pkg::MODE_CLEAR:
                begin
                    total_next          = '0;
                    leaves_next         = '0;
                    merges_next         = '0;
                    res_next.roots_left = '0;
                end
                hufb_pkg::MODE_LOAD:
                begin
                    if (load_ok)
                    begin
                        total_next            = total_reg + 9'd1;
                        leaves_next           = leaves_reg + 9'd1;
                        res_next.new_node     = leaves_reg;
                        res_next.merged_count = leaf_cnt;
                        res_next.roots_left   = total_reg + 9'd1;
                    end
                    else
                    begin
                        res_next.status = hufb_pkg::ST_FULL;
                    end
                end
                hufb_pkg::MODE_MERGE:
                begin
                    if (!sts.merge_go)
                    begin
                        res_next.status = hufb_pkg::ST_LOW_ROOTS;
                    end
                end
                default:
                begin
                    res_next.status = hufb_pkg::ST_OK;
                end
            endcase
        end
        else if (cmd.merge)
        begin
            total_next            = total_reg - 9'd1;
            merges_next           = merges_reg + 8'd1;
            rd_idx_next           = hi_idx + 9'd1;
            res_next.status       = hufb_pkg::ST_OK;
            res_next.left_node    = lo_id;
            res_next.right_node   = hi_id;
            res_next.new_node     = nid;
            res_next.merged_count = sum;
            res_next.roots_left   = total_reg - 9'd1;
        end
        else if (cmd.sym_l)
        begin
            res_next.left_symbol = (lo_id < CAP_ID) ? sym_rdata : '0;
        end
        else if (cmd.sym_r)
        begin
            res_next.right_symbol = (hi_id < CAP_ID) ? sym_rdata : '0;
        end
        else if (issue)
        begin
            rd_idx_next = rd_idx_reg + 9'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg   <= '0;
            leaves_reg  <= '0;
            merges_reg  <= '0;
            rd_idx_reg  <= '0;
            rd_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            total_reg  <= total_next;
            leaves_reg <= leaves_next;
            merges_reg <= merges_next;
            rd_idx_reg <= rd_idx_next;
            rd_vld_reg <= issue;
            if (cmd.publish)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_pend_reg <= rd_idx_reg;
        res_reg     <= res_next;
        if (cmd.capture)
        begin
            item_reg <= item;
        end
        if (cmd.publish)
        begin
            out_reg <= res_reg;
        end
        if (cmd.scan && rd_vld_reg)
        begin
            if (rd_pend_reg == '0)
            begin
                m1_cnt_reg <= root_rdata.cnt;
                m1_idx_reg <= rd_pend_reg;
                m1_id_reg  <= root_rdata.id;
                m2_ok_reg  <= 1'b0;
            end
            else if (root_rdata.cnt < m1_cnt_reg)
            begin
                m2_cnt_reg <= m1_cnt_reg;
                m2_idx_reg <= m1_idx_reg;
                m2_id_reg  <= m1_id_reg;
                m2_ok_reg  <= 1'b1;
                m1_cnt_reg <= root_rdata.cnt;
                m1_idx_reg <= rd_pend_reg;
                m1_id_reg  <= root_rdata.id;
            end
            else if (!m2_ok_reg || (root_rdata.cnt < m2_cnt_reg))
            begin
                m2_cnt_reg <= root_rdata.cnt;
                m2_idx_reg <= rd_pend_reg;
                m2_id_reg  <= root_rdata.id;
                m2_ok_reg  <= 1'b1;
            end
        end
    end

    assign result_valid = out_vld_reg;
    assign result       = out_reg;

endmodule

// ===== src/huffman_tree_builder_core.sv =====
// ----------------------------------------------------------------------------
// Huffman tree builder core
// Keeps a list of tree roots; clears it, loads leaves or merges the two lightest roots.
// ----------------------------------------------------------------------------
// One item is in flight at a time and each item yields one result transaction.
// A clear, a load, an ignored item or a refused merge is decoded into the result
// register, copied to the output register in the finish state, and then the next
// item is taken. A merge walks the single read port of the root memory once to
// find the two lightest roots and once more, from the higher of the two
// positions, to close the gap. Any wait for the output register holds the
// controller in its finish state. A new item is taken while the previous result
// still waits in the output register.
module huffman_tree_builder_core #(
    parameter int CAPACITY = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  hufb_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output hufb_pkg::result_t result
);

    hufb_pkg::ctl_cmd_t cmd;
    hufb_pkg::ctl_sts_t sts;

    hufb_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    hufb_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ===== src/hufb_checker.sv =====
// ----------------------------------------------------------------------------
// Huffman tree builder checker
// Port level properties of the core, attached to every instance by bind.
// ----------------------------------------------------------------------------
`include "huffman_tree_builder_core_macros.svh"

module hufb_checker #(
    parameter int CAPACITY = 256
) (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_stall,
    input hufb_pkg::item_t   item,
    input logic              result_valid,
    input logic              result_stall,
    input hufb_pkg::result_t result
);

    localparam logic [hufb_pkg::NODE_W-1:0] CAP_ID = hufb_pkg::NODE_W'(CAPACITY);

    logic low_roots_res;
    logic low_roots_clean;
    logic merge_res;

    assign low_roots_res   = result_valid && (result.status == hufb_pkg::ST_LOW_ROOTS);
    assign low_roots_clean = (result.new_node == '0) && (result.merged_count == '0)
                             && (result.left_node == '0);
    assign merge_res       = result_valid && (result.new_node >= CAP_ID);

    `HUFB_ASSERT_NEXT(a_item_held, item_valid && item_stall, item_valid && $stable(item))
    `HUFB_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid && $stable(result))
    `HUFB_ASSERT_NOW(a_roots_bound, result_valid, result.roots_left <= CAP_ID)
    `HUFB_ASSERT_NOW(a_low_roots_empty, low_roots_res, low_roots_clean)
    `HUFB_ASSERT_NOW(a_merge_children, merge_res, result.left_node != result.right_node)

endmodule

bind huffman_tree_builder_core hufb_checker #(
    .CAPACITY (CAPACITY)
) u_hufb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
